// ===== hdl/grtc_pkg.sv =====
// shared types and constants for the guest region table checker
package grtc_pkg;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned LIMIT_W  = 33;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned INDEX_W  = 6;

  localparam logic [LIMIT_W-1:0] GUEST_SIZE_RST = 33'h1_0000_0000;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_CHECK = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_VALUE   = 2'd1,
    ST_BAD_ADDRESS = 2'd2,
    ST_FULL        = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SCN_IDLE,
    SCN_PRE,
    SCN_SCAN,
    SCN_FIN
  } scan_state_e;

  typedef struct packed {
    opcode_e             opcode;
    logic [ADDR_W-1:0]   address;
    logic [ADDR_W-1:0]   length;
    logic [KIND_W-1:0]   region_kind;
  } in_word_t;

  typedef struct packed {
    status_e             status;
    logic [INDEX_W-1:0]  entry_index;
    logic [KIND_W-1:0]   found_kind;
  } out_word_t;

  // one stored region: [start_addr, end_addr)
  typedef struct packed {
    logic [ADDR_W-1:0]   start_addr;
    logic [LIMIT_W-1:0]  end_addr;
    logic [KIND_W-1:0]   kind;
  } region_entry_t;

endpackage

// ===== hdl/grtc_ram.sv =====
// generic single-write, single-read ram with registered read data
module grtc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/grtc_scan.sv =====
// sequencer that scans the region table one entry a cycle and decides each word
module grtc_scan import grtc_pkg::*; #(
  parameter int unsigned MAX_REGIONS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           idle_o,
  input  in_word_t                       item_i,
  input  logic [LIMIT_W-1:0]             guest_size_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output out_word_t                      res_o,
  output logic                           ram_re_o,
  output logic [$clog2(MAX_REGIONS)-1:0] ram_raddr_o,
  input  region_entry_t                  ram_rdata_i,
  output logic                           ram_we_o,
  output logic [$clog2(MAX_REGIONS)-1:0] ram_waddr_o,
  output region_entry_t                  ram_wdata_o
);

  localparam int unsigned IDX_W = $clog2(MAX_REGIONS);
  localparam int unsigned CNT_W = $clog2(MAX_REGIONS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REGIONS);

  scan_state_e        state_q, state_d;
  in_word_t           item_q;
  logic [LIMIT_W-1:0] limit_q, limit_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   iss_q, iss_d;
  logic               dvld_q, dvld_d;
  logic [IDX_W-1:0]   didx_q, didx_d;
  out_word_t          res_q, res_d;

  // decision terms
  logic [LIMIT_W-1:0] addr_x;
  logic [LIMIT_W-1:0] sum_x;
  logic               len_zero;
  logic               outside;
  logic               overlap;
  logic               in_region;
  logic               past_end;
  logic               hit;
  logic               last_data;
  logic               full;
  logic               commit;

  always_comb begin
    addr_x    = {1'b0, item_q.address};
    sum_x     = addr_x + {1'b0, item_q.length};
    len_zero  = (item_q.length == '0);
    // last byte at or above guest size is the same as sum above it
    outside   = (addr_x >= guest_size_i) || (sum_x > guest_size_i);
    overlap   = !((addr_x >= ram_rdata_i.end_addr) ||
                  (limit_q <= {1'b0, ram_rdata_i.start_addr}));
    in_region = (item_q.address >= ram_rdata_i.start_addr) &&
                (addr_x < ram_rdata_i.end_addr);
    past_end  = (limit_q > ram_rdata_i.end_addr);
    hit       = dvld_q && ((item_q.opcode == OP_ADD) ? overlap : in_region);
    last_data = dvld_q && ((CNT_W'(didx_q) + CNT_W'(1)) == cnt_q);
    full      = (cnt_q == CNT_MAX);
    commit    = 1'b0;
    if (item_q.opcode == OP_ADD) begin
      if (state_q == SCN_PRE) begin
        commit = !len_zero && (cnt_q == '0);
      end else if (state_q == SCN_SCAN) begin
        commit = !hit && last_data && !full;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SCN_IDLE: begin
        if (start_i) begin
          state_d = SCN_PRE;
        end
      end
      SCN_PRE: begin
        if (len_zero || (item_q.opcode == OP_CHECK && outside) || cnt_q == '0) begin
          state_d = SCN_FIN;
        end else begin
          state_d = SCN_SCAN;
        end
      end
      SCN_SCAN: begin
        if (hit || last_data) begin
          state_d = SCN_FIN;
        end
      end
      SCN_FIN: begin
        if (res_ready_i) begin
          state_d = SCN_IDLE;
        end
      end
      default: state_d = SCN_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    limit_d     = limit_q;
    cnt_d       = commit ? cnt_q + CNT_W'(1) : cnt_q;
    iss_d       = iss_q;
    dvld_d      = 1'b0;
    didx_d      = didx_q;
    res_d       = res_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = iss_q[IDX_W-1:0];
    ram_we_o    = commit;
    ram_waddr_o = cnt_q[IDX_W-1:0];
    ram_wdata_o.start_addr = item_q.address;
    ram_wdata_o.end_addr   = (state_q == SCN_PRE) ? sum_x : limit_q;
    ram_wdata_o.kind       = item_q.region_kind;
    case (state_q)
      SCN_PRE: begin
        limit_d = sum_x;
        iss_d   = '0;
        res_d   = '{status: ST_BAD_ADDRESS, entry_index: '0, found_kind: '0};
        if (len_zero) begin
          res_d.status = ST_BAD_VALUE;
        end else if (item_q.opcode == OP_ADD && cnt_q == '0) begin
          res_d = '{status: ST_OK, entry_index: '0, found_kind: item_q.region_kind};
        end
      end
      SCN_SCAN: begin
        ram_re_o = (iss_q < cnt_q);
        if (ram_re_o) begin
          iss_d = iss_q + CNT_W'(1);
        end
        dvld_d = ram_re_o && !hit;
        didx_d = iss_q[IDX_W-1:0];
        if (hit) begin
          if (item_q.opcode == OP_ADD) begin
            res_d = '{status: ST_BAD_VALUE, entry_index: '0, found_kind: '0};
          end else if (past_end) begin
            res_d = '{status: ST_BAD_ADDRESS, entry_index: '0, found_kind: '0};
          end else begin
            res_d = '{status: ST_OK, entry_index: INDEX_W'(didx_q),
                      found_kind: ram_rdata_i.kind};
          end
        end else if (last_data) begin
          if (item_q.opcode == OP_CHECK) begin
            res_d = '{status: ST_BAD_ADDRESS, entry_index: '0, found_kind: '0};
          end else if (full) begin
            res_d = '{status: ST_FULL, entry_index: '0, found_kind: '0};
          end else begin
            res_d = '{status: ST_OK, entry_index: INDEX_W'(cnt_q),
                      found_kind: item_q.region_kind};
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SCN_IDLE;
      cnt_q   <= '0;
      iss_q   <= '0;
      dvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      iss_q   <= iss_d;
      dvld_q  <= dvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q == SCN_IDLE) begin
      item_q <= item_i;
    end
    limit_q <= limit_d;
    didx_q  <= didx_d;
    res_q   <= res_d;
  end

  assign idle_o      = (state_q == SCN_IDLE);
  assign res_valid_o = (state_q == SCN_FIN);
  assign res_o       = res_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MAX)
    else $error("region count beyond table size");

  a_write_add_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |=> (res_q.status == ST_OK && item_q.opcode == OP_ADD))
    else $error("table written without a successful add");

  a_write_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("table write did not advance the count");

  a_no_read_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> !ram_re_o)
    else $error("table read and write in the same cycle");

endmodule

// ===== hdl/guest_region_table_checker_core.sv =====
// top level of the guest region table checker
// Keeps up to MAX_REGIONS non-overlapping guest memory regions in one
// on-chip ram (start, 33-bit end, kind per entry) and answers one word at a
// time: an add word appends a region unless its length is zero, it overlaps
// a stored region, or the table is full; a check word validates an access
// against the guest size and reports the index and kind of the first stored
// region that holds it. Each word produces exactly one result word. A word
// that scans the whole table passes through a bound check, one ram read
// per stored region with registered read data, and a final step that
// hands the result on; a check or add that hits an entry stops the scan
// there, and refusals decided before the scan (or an add to an empty
// table) skip it. The next word is accepted in the cycle after the result
// leaves the sequencer. The scan reads the table through the single read
// port of the table ram. The result sits in an output register, so the
// next word is accepted while the previous result waits. guest_size is
// written on the cfg channel and resets to 4 GiB; the user must write it
// only while the block is idle, which the block itself does not enforce.
// The region count resets to zero, the ram needs no clear.
module guest_region_table_checker_core import grtc_pkg::*; #(
  parameter int unsigned MAX_REGIONS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration: guest size
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [LIMIT_W-1:0] cfg_data_i,
  // request words
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_word_t           in_word_i,
  // result words
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_word_t          out_word_o
);

  localparam int unsigned IDX_W = $clog2(MAX_REGIONS);
  localparam int unsigned ENT_W = $bits(region_entry_t);

  logic [LIMIT_W-1:0] guest_size_q;

  logic               scan_idle;
  logic               res_valid;
  logic               res_ready;
  out_word_t          res_word;

  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  region_entry_t      ram_rdata;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  region_entry_t      ram_wdata;

  logic               out_valid_q, out_valid_d;
  out_word_t          out_word_q;

  // guest size register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      guest_size_q <= GUEST_SIZE_RST;
    end else if (cfg_valid_i) begin
      guest_size_q <= cfg_data_i;
    end
  end

  // a new word enters only when the sequencer has finished the last one
  assign in_ready_o = scan_idle;

  grtc_scan #(
    .MAX_REGIONS (MAX_REGIONS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (in_valid_i),
    .idle_o       (scan_idle),
    .item_i       (in_word_i),
    .guest_size_i (guest_size_q),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res_word),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata)
  );

  // region table: start, end and kind packed into one entry
  grtc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_REGIONS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // output register decouples the result from the downstream stall
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_word_q <= res_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // a refused word never reports an index or kind
  a_refusal_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.status != ST_OK) |->
      (out_word_o.entry_index == '0 && out_word_o.found_kind == '0))
    else $error("refused result carries index or kind");

  // no word accepted while the sequencer still holds a result
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !res_valid)
    else $error("result pending right after a new word");

  // a finished result is never dropped while the output register is busy
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res_ready) |=> res_valid)
    else $error("sequencer dropped a stalled result");

endmodule
